### sv/x86_instruction_length_decoder_top_assert.svh
// ----------------------------------------------------------------------------
// x86 instruction length decoder assertion macros
// shared property forms for the decoder checks
// ----------------------------------------------------------------------------
`ifndef X86_INSTRUCTION_LENGTH_DECODER_TOP_ASSERT_SVH
`define X86_INSTRUCTION_LENGTH_DECODER_TOP_ASSERT_SVH

// same-cycle implication
`define XILD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("xild check failed");

// next-cycle implication
`define XILD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("xild check failed");

`endif

### sv/xild_pkg.sv
// ----------------------------------------------------------------------------
// xild_pkg
// constants and helpers for the x86 instruction length decoder
// ----------------------------------------------------------------------------
package xild_pkg;

    localparam int WINDOW_BYTES_DEF = 16;
    localparam int WIN_BITS         = 128;
    localparam int MAX_INSN_LEN     = 15;

    typedef logic [WIN_BITS-1:0] win_t;
    typedef logic [7:0]          byte_t;

    localparam byte_t OP_OPSIZE = 8'h66;
    localparam byte_t OP_ADSIZE = 8'h67;
    localparam byte_t OP_REPNE  = 8'hF2;
    localparam byte_t OP_REP    = 8'hF3;
    localparam byte_t OP_REX_LO = 8'h40;
    localparam byte_t OP_REX_HI = 8'h4F;
    localparam byte_t OP_RET    = 8'hC3;
    localparam byte_t OP_RETN   = 8'hC2;
    localparam byte_t OP_CALL   = 8'hE8;
    localparam byte_t OP_JMP    = 8'hE9;
    localparam byte_t OP_PUSHI  = 8'h68;
    localparam byte_t OP_GRP3   = 8'hF7;
    localparam byte_t OP_GRP1B  = 8'h83;
    localparam byte_t OP_GRP1D  = 8'h81;

    // single-byte and fixed-length opcodes
    localparam byte_t OP_INC_LO      = 8'h40;
    localparam byte_t OP_PUSH_LO     = 8'h50;
    localparam byte_t OP_POP_HI      = 8'h5F;
    localparam byte_t OP_NOP         = 8'h90;
    localparam byte_t OP_CWDE        = 8'h98;
    localparam byte_t OP_CDQ         = 8'h99;
    localparam byte_t OP_PUSH_IB     = 8'h6A;
    localparam byte_t OP_JMP_SHORT   = 8'hEB;
    localparam byte_t OP_MOV_EAX_MO  = 8'hA1;
    localparam byte_t OP_MOV_MO_EAX  = 8'hA3;
    localparam byte_t OP_MOV_IMM_LO  = 8'hB8;
    localparam byte_t OP_MOV_IMM_HI  = 8'hBF;

    // modrm opcodes
    localparam byte_t OP_ADD_GV      = 8'h03;
    localparam byte_t OP_OR_GV       = 8'h0B;
    localparam byte_t OP_SBB_GV      = 8'h1B;
    localparam byte_t OP_AND_GV      = 8'h23;
    localparam byte_t OP_SUB_GV      = 8'h2B;
    localparam byte_t OP_XOR_GV      = 8'h33;
    localparam byte_t OP_CMP_GV      = 8'h3B;
    localparam byte_t OP_TEST_EV     = 8'h85;
    localparam byte_t OP_XCHG_EV     = 8'h87;
    localparam byte_t OP_MOV_EB_GB   = 8'h88;
    localparam byte_t OP_MOV_EV_GV   = 8'h89;
    localparam byte_t OP_MOV_GB_EB   = 8'h8A;
    localparam byte_t OP_MOV_GV_EV   = 8'h8B;
    localparam byte_t OP_LEA         = 8'h8D;
    localparam byte_t OP_GRP5        = 8'hFF;
    localparam byte_t OP_MOV_EB_IB   = 8'hC6;
    localparam byte_t OP_MOV_EV_IZ   = 8'hC7;

    // modrm fields
    localparam logic [1:0] MOD_MEM    = 2'd0;
    localparam logic [1:0] MOD_DISP8  = 2'd1;
    localparam logic [1:0] MOD_DISP32 = 2'd2;
    localparam logic [1:0] MOD_REG    = 2'd3;
    localparam logic [2:0] RM_SIB     = 3'd4;
    localparam logic [2:0] RM_DISP32  = 3'd5;

    function automatic byte_t get_byte(input win_t win, input logic [3:0] idx);
        return win[{idx, 3'b000} +: 8];
    endfunction

    function automatic logic is_prefix(input byte_t b);
        return (b == OP_OPSIZE) || (b == OP_ADSIZE) || (b == OP_REPNE) || (b == OP_REP);
    endfunction

endpackage

### sv/x86_instruction_length_decoder_top.sv
// ----------------------------------------------------------------------------
// x86_instruction_length_decoder_top
// byte length of the instruction at the start of a 16-byte window
// ----------------------------------------------------------------------------
// the window and a valid bit are registered on the accepting edge, then done and the length are registered from them
// throughput: one word per cycle, busy is never raised
// the decode is one pass of logic between the window register and the result
// register; results cannot be stalled by the receiver
// reset clears the valid pipeline and selects the 32-bit table
module x86_instruction_length_decoder_top #(
    parameter int WINDOW_BYTES = xild_pkg::WINDOW_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] bytes_lo,
    input  logic [63:0] bytes_hi,
    input  logic        long_mode_we,
    input  logic        long_mode_wdata,
    output logic        done,
    output logic [3:0]  insn_length
);

    localparam logic [4:0] WinLim = 5'(WINDOW_BYTES);
    localparam logic [5:0] WinLen = 6'(WINDOW_BYTES);
    localparam logic [5:0] MaxLen = 6'(xild_pkg::MAX_INSN_LEN);

    logic             long_mode_reg;
    logic             long_mode_next;
    logic             in_valid_reg;
    logic             in_valid_next;
    xild_pkg::win_t   win_reg;
    logic             done_reg;
    logic             done_next;
    logic [3:0]       insn_length_reg;
    logic [3:0]       insn_length_next;

    assign busy           = 1'b0;
    assign in_valid_next  = start;
    assign done_next      = in_valid_reg;
    assign long_mode_next = long_mode_we ? long_mode_wdata : long_mode_reg;

    // 32-bit table
    logic [5:0] len32;
    logic       bad32;

    always_comb
    begin
        xild_pkg::byte_t op;
        xild_pkg::byte_t m;
        logic [1:0]      mod;
        logic [2:0]      rm;
        logic [5:0]      disp;
        logic            sib;
        op    = xild_pkg::get_byte(win_reg, 4'd0);
        m     = xild_pkg::get_byte(win_reg, 4'd1);
        mod   = m[7:6];
        rm    = m[2:0];
        sib   = 1'b0;
        disp  = 6'd0;
        if (mod == xild_pkg::MOD_REG)
            disp = 6'd0;
        else if (mod == xild_pkg::MOD_MEM && rm == xild_pkg::RM_DISP32)
            disp = 6'd4;
        else if (rm == xild_pkg::RM_SIB)
            sib = 1'b1;
        else if (mod == xild_pkg::MOD_DISP8)
            disp = 6'd1;
        else if (mod == xild_pkg::MOD_DISP32)
            disp = 6'd4;
        len32 = 6'd0;
        bad32 = 1'b0;
        if ((op >= xild_pkg::OP_INC_LO && op <= xild_pkg::OP_POP_HI) ||
            op == xild_pkg::OP_NOP || op == xild_pkg::OP_CWDE || op == xild_pkg::OP_CDQ)
            len32 = 6'd1;
        else if (op >= xild_pkg::OP_MOV_IMM_LO && op <= xild_pkg::OP_MOV_IMM_HI)
            len32 = 6'd5;
        else
        begin
            case (op)
                xild_pkg::OP_PUSH_IB, xild_pkg::OP_JMP_SHORT:
                    len32 = 6'd2;
                xild_pkg::OP_PUSHI, xild_pkg::OP_MOV_EAX_MO, xild_pkg::OP_MOV_MO_EAX:
                    len32 = 6'd5;
                xild_pkg::OP_ADD_GV, xild_pkg::OP_OR_GV, xild_pkg::OP_SBB_GV,
                xild_pkg::OP_AND_GV, xild_pkg::OP_SUB_GV, xild_pkg::OP_XOR_GV,
                xild_pkg::OP_CMP_GV, xild_pkg::OP_TEST_EV, xild_pkg::OP_XCHG_EV,
                xild_pkg::OP_MOV_EV_GV, xild_pkg::OP_MOV_GV_EV, xild_pkg::OP_LEA,
                xild_pkg::OP_GRP5:
                begin
                    len32 = 6'd2 + disp;
                    bad32 = sib;
                end
                xild_pkg::OP_GRP3:
                begin
                    len32 = 6'd2 + disp + ((m[5:3] == 3'd0) ? 6'd4 : 6'd0);
                    bad32 = sib;
                end
                xild_pkg::OP_GRP1B, xild_pkg::OP_MOV_EB_IB:
                begin
                    len32 = 6'd3 + disp;
                    bad32 = sib;
                end
                xild_pkg::OP_GRP1D, xild_pkg::OP_MOV_EV_IZ:
                begin
                    len32 = 6'd6 + disp;
                    bad32 = sib;
                end
                // returns and relative branches cannot be relocated
                xild_pkg::OP_RETN, xild_pkg::OP_RET, xild_pkg::OP_CALL, xild_pkg::OP_JMP:
                    bad32 = 1'b1;
                default:
                    bad32 = 1'b1;
            endcase
        end
    end

    // 64-bit table
    logic [5:0] len64;
    logic       bad64;

    always_comb
    begin
        logic            found;
        logic            opsize;
        logic [3:0]      p;
        xild_pkg::byte_t b;
        xild_pkg::byte_t op;
        xild_pkg::byte_t m;
        xild_pkg::byte_t s;
        logic            rex;
        logic            rexw;
        logic [4:0]      q;
        logic [4:0]      m_pos;
        logic [4:0]      s_pos;
        logic [1:0]      mod;
        logic [2:0]      rm;
        logic [5:0]      ml;
        logic [5:0]      imm;
        logic            use_modrm;
        found  = 1'b0;
        opsize = 1'b0;
        p      = 4'd0;
        for (int i = 0; i < 16; i++)
        begin
            if (!found && i < WINDOW_BYTES)
            begin
                if (!xild_pkg::is_prefix(xild_pkg::get_byte(win_reg, 4'(i))))
                begin
                    found = 1'b1;
                    p     = 4'(i);
                end
                else if (xild_pkg::get_byte(win_reg, 4'(i)) == xild_pkg::OP_OPSIZE)
                    opsize = 1'b1;
            end
        end
        b     = xild_pkg::get_byte(win_reg, p);
        rex   = (b >= xild_pkg::OP_REX_LO) && (b <= xild_pkg::OP_REX_HI);
        rexw  = rex & b[3];
        q     = {1'b0, p} + {4'd0, rex};
        op    = xild_pkg::get_byte(win_reg, q[3:0]);
        m_pos = q + 5'd1;
        s_pos = q + 5'd2;
        m     = xild_pkg::get_byte(win_reg, m_pos[3:0]);
        s     = xild_pkg::get_byte(win_reg, s_pos[3:0]);
        mod   = m[7:6];
        rm    = m[2:0];
        bad64 = !found || (q >= WinLim);
        len64 = 6'd0;
        imm   = 6'd0;
        use_modrm = 1'b1;
        ml    = 6'd1;
        case (op)
            xild_pkg::OP_MOV_EB_GB, xild_pkg::OP_MOV_EV_GV, xild_pkg::OP_MOV_GB_EB,
            xild_pkg::OP_MOV_GV_EV, xild_pkg::OP_LEA:
                imm = 6'd0;
            xild_pkg::OP_GRP1B:
                imm = 6'd1;
            xild_pkg::OP_GRP1D:
                imm = (opsize && !rexw) ? 6'd2 : 6'd4;
            default:
                use_modrm = 1'b0;
        endcase
        if (mod == xild_pkg::MOD_REG)
            ml = 6'd1;
        else if (mod == xild_pkg::MOD_MEM && rm == xild_pkg::RM_DISP32)
            ml = 6'd5;
        else if (rm == xild_pkg::RM_SIB)
        begin
            if (mod == xild_pkg::MOD_MEM && s[2:0] == xild_pkg::RM_DISP32)
                ml = 6'd6;
            else if (mod == xild_pkg::MOD_DISP8)
                ml = 6'd3;
            else if (mod == xild_pkg::MOD_DISP32)
                ml = 6'd6;
            else
                ml = 6'd2;
        end
        else if (mod == xild_pkg::MOD_DISP8)
            ml = 6'd2;
        else if (mod == xild_pkg::MOD_DISP32)
            ml = 6'd5;
        if (op >= xild_pkg::OP_PUSH_LO && op <= xild_pkg::OP_POP_HI)
            len64 = {1'b0, q} + 6'd1;
        else if (use_modrm)
        begin
            len64 = {1'b0, q} + 6'd1 + ml + imm;
            if (m_pos >= WinLim)
                bad64 = 1'b1;
            if (mod == xild_pkg::MOD_MEM && rm == xild_pkg::RM_DISP32)
                bad64 = 1'b1;
            if (mod != xild_pkg::MOD_REG && rm == xild_pkg::RM_SIB && s_pos >= WinLim)
                bad64 = 1'b1;
        end
        else
            bad64 = 1'b1;
    end

    always_comb
    begin
        logic [5:0] len;
        logic       bad;
        len = long_mode_reg ? len64 : len32;
        bad = long_mode_reg ? bad64 : bad32;
        if (bad || len > WinLen || len > MaxLen)
            insn_length_next = 4'd0;
        else
            insn_length_next = len[3:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_mode_reg <= 1'b0;
            in_valid_reg  <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            long_mode_reg <= long_mode_next;
            in_valid_reg  <= in_valid_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            win_reg <= {bytes_hi, bytes_lo};
        if (in_valid_reg)
            insn_length_reg <= insn_length_next;
    end

    assign done        = done_reg;
    assign insn_length = insn_length_reg;

`include "x86_instruction_length_decoder_top_assert.svh"

    `XILD_ASSERT_NEXT(a_done_follows_start, clk, rst_n, start && !busy, ##1 done)
    `XILD_ASSERT_NEXT(a_no_spurious_done, clk, rst_n, !in_valid_reg, !done)
    `XILD_ASSERT_NOW(a_len_in_window, clk, rst_n, done, {1'b0, insn_length} <= WinLim)

endmodule
